[src/pid_dzc_pkg.sv]
// Shared widths, register indexes and state type for the PID controller with dead zone and clamp.
package pid_dzc_pkg;

  // Sample, error and gain widths.
  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int INTEG_W    = 40;
  localparam int SUM_W      = INTEG_W + 1;
  localparam int INT_FRAC   = 16;
  localparam int KP_W       = 16;
  localparam int KI_W       = 16;
  localparam int KD_W       = 24;
  localparam int STEP_W     = 16;
  localparam int BAND_W     = 17;
  localparam int LIMIT_W    = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR = 3'd6;

  // Radix-4 serial multiplier: multiplicand parallel, multiplier two bits per cycle.
  localparam int MCAND_W    = INTEG_W;
  localparam int MPLR_W     = KD_W;
  localparam int PROD_W     = MCAND_W + MPLR_W;
  localparam int ACC_W      = MCAND_W + 3;
  localparam int DIGITS     = MPLR_W / 2;
  localparam int CNT_W      = $clog2(DIGITS + 1);

  // Proportional plus derivative sum and the final scaling.
  localparam int PD_W       = 43;
  localparam int OUT_SHIFT  = 24;
  localparam int Y_W        = PROD_W - OUT_SHIFT;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_BAND,
    ST_MUL2,
    ST_SUM,
    ST_SAT,
    ST_CLAMP
  } state_t;

endpackage

[src/pid_dzc_smul.sv]
// Radix-4 Booth serial multiplier that retires two multiplier bits per cycle.
module pid_dzc_smul import pid_dzc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic signed [MPLR_W-1:0]  mplr,
  output logic                      done,
  output logic signed [PROD_W-1:0]  product
);

  logic signed [MCAND_W-1:0] a_reg;
  logic signed [ACC_W-1:0]   a_ext;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   partial;
  logic signed [ACC_W-1:0]   sum;
  logic [MPLR_W-1:0]         blo;
  logic                      bprev;
  logic [CNT_W-1:0]          count;

  assign a_ext = {{(ACC_W-MCAND_W){a_reg[MCAND_W-1]}}, a_reg};

  // Booth digit from the two low multiplier bits and the last bit shifted out.
  always_comb begin
    unique case ({blo[1:0], bprev})
      3'b000, 3'b111: partial = '0;
      3'b001, 3'b010: partial = a_ext;
      3'b011:         partial = a_ext <<< 1;
      3'b100:         partial = -(a_ext <<< 1);
      3'b101, 3'b110: partial = -a_ext;
    endcase
  end

  assign sum     = acc + partial;
  assign done    = (count == CNT_W'(DIGITS));
  assign product = {acc[MCAND_W-1:0], blo};

  // Digit counter; the unit rests with the count at its end value.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(DIGITS);
    end else if (load) begin
      count <= '0;
    end else if (!done) begin
      count <= count + CNT_W'(1);
    end
  end

  // Accumulate and shift; low product bits replace the multiplier bits as they retire.
  always_ff @(posedge clk) begin
    if (load) begin
      a_reg <= mcand;
      acc   <= '0;
      blo   <= mplr;
      bprev <= 1'b0;
    end else if (!done) begin
      acc   <= sum >>> 2;
      blo   <= {sum[1:0], blo[MPLR_W-1:2]};
      bprev <= blo[1];
    end
  end

endmodule

[src/pid_controller_deadzone_clamp_core.sv]
// PID controller with error dead zone, saturating integral, output clamp and output dead band.
// A request is accepted only in the idle state, so one is finished before the next is taken.
// Each request makes two passes through the radix-4 serial multipliers:
// error times step time together with the P and D products, then integral times gain.
// A new request is accepted while the previous result waits in the output register.
// Synchronous reset clears the state, integral and last error; gains go to 0, limits to -1.
module pid_controller_deadzone_clamp_core import pid_dzc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] target,
  input  logic signed [SAMPLE_W-1:0] sensed,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] drive
);

  state_t state, state_next;

  logic signed [KP_W-1:0]    prop_gain;
  logic signed [KI_W-1:0]    integ_gain;
  logic signed [KD_W-1:0]    deriv_gain;
  logic [STEP_W-1:0]         step_time;
  logic signed [BAND_W-1:0]  error_band;
  logic signed [LIMIT_W-1:0] drive_limit;
  logic signed [LIMIT_W-1:0] drive_floor;

  logic signed [ERR_W-1:0]   e_raw;
  logic signed [ERR_W-1:0]   e_dz;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [DIFF_W-1:0]  e_ext;
  logic signed [DIFF_W-1:0]  band_ext;
  logic signed [DIFF_W-1:0]  e_diff;
  logic                      band_on;
  logic                      e_small;

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [INTEG_W-1:0] integ_add;
  logic signed [INTEG_W-1:0] integ_dz;
  logic signed [SUM_W-1:0]   integ_wide;
  logic signed [SUM_W-1:0]   integ_ext;
  logic signed [SUM_W-1:0]   band_wide;
  logic                      i_small;

  logic                      m0_load;
  logic                      pd_load;
  logic                      m0_done;
  logic                      p_done;
  logic                      d_done;
  logic                      mul1_end;
  logic signed [MCAND_W-1:0] m0_mcand;
  logic signed [MPLR_W-1:0]  m0_mplr;
  logic signed [PROD_W-1:0]  m0_prod;
  logic signed [PROD_W-1:0]  p_prod;
  logic signed [PROD_W-1:0]  d_prod;

  logic signed [PD_W-1:0]     pd_sum;
  logic signed [PROD_W-1:0]   total;
  logic signed [Y_W-1:0]      y_wide;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic signed [SAMPLE_W-1:0] y_sat_next;
  logic signed [SAMPLE_W-1:0] y_fin;
  logic                       out_free;
  logic                       drive_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      step_time   <= '0;
      error_band  <= '1;
      drive_limit <= '1;
      drive_floor <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_data[KP_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= cfg_data[KI_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data[KD_W-1:0];
        REG_STEP_TIME:   step_time   <= cfg_data[STEP_W-1:0];
        REG_ERROR_BAND:  error_band  <= cfg_data[BAND_W-1:0];
        REG_DRIVE_LIMIT: drive_limit <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_FLOOR: drive_floor <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Error dead zone and the difference against the previous error.
  assign band_on  = !error_band[BAND_W-1];
  assign e_ext    = {e_raw[ERR_W-1], e_raw};
  assign band_ext = {error_band[BAND_W-1], error_band};
  assign e_small  = (e_ext <= band_ext) && (e_ext >= -band_ext);
  assign e_dz     = (band_on && e_small) ? '0 : e_raw;
  assign e_diff   = {e_dz[ERR_W-1], e_dz} - {last_error[ERR_W-1], last_error};

  // Saturating integral update with the error times step time product.
  assign integ_wide = {integral_sum[INTEG_W-1], integral_sum} + m0_prod[SUM_W-1:0];
  always_comb begin
    if (integ_wide[SUM_W-1] != integ_wide[INTEG_W-1]) begin
      integ_add = integ_wide[SUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_add = integ_wide[INTEG_W-1:0];
    end
  end

  // Integral dead zone: the band scaled to the integral's fraction bits.
  assign integ_ext = {integral_sum[INTEG_W-1], integral_sum};
  assign band_wide = {{(SUM_W-BAND_W-INT_FRAC){error_band[BAND_W-1]}}, error_band,
                      {INT_FRAC{1'b0}}};
  assign i_small   = (integ_ext <= band_wide) && (integ_ext >= -band_wide);
  assign integ_dz  = (band_on && i_small) ? '0 : integral_sum;

  // The shared multiplier forms e times step time first, then integral times gain.
  always_comb begin
    if (state == ST_BAND) begin
      m0_mcand = integ_dz;
      m0_mplr  = {{(MPLR_W-KI_W){integ_gain[KI_W-1]}}, integ_gain};
    end else begin
      m0_mcand = {{(MCAND_W-ERR_W){e_raw[ERR_W-1]}}, e_raw};
      m0_mplr  = {{(MPLR_W-STEP_W){1'b0}}, step_time};
    end
  end

  pid_dzc_smul u_mul_main (
    .clk     (clk),
    .rst     (rst),
    .load    (m0_load),
    .mcand   (m0_mcand),
    .mplr    (m0_mplr),
    .done    (m0_done),
    .product (m0_prod)
  );

  pid_dzc_smul u_mul_prop (
    .clk     (clk),
    .rst     (rst),
    .load    (pd_load),
    .mcand   ({{(MCAND_W-ERR_W){e_dz[ERR_W-1]}}, e_dz}),
    .mplr    ({{(MPLR_W-KP_W){prop_gain[KP_W-1]}}, prop_gain}),
    .done    (p_done),
    .product (p_prod)
  );

  pid_dzc_smul u_mul_deriv (
    .clk     (clk),
    .rst     (rst),
    .load    (pd_load),
    .mcand   ({{(MCAND_W-DIFF_W){e_diff[DIFF_W-1]}}, e_diff}),
    .mplr    (deriv_gain),
    .done    (d_done),
    .product (d_prod)
  );

  assign mul1_end = m0_done && p_done && d_done;
  assign out_free = !out_valid || out_ready;

  // Saturate the scaled sum to the sample width.
  assign y_wide = total[PROD_W-1:OUT_SHIFT];
  always_comb begin
    if (y_wide[Y_W-1:SAMPLE_W-1] != {(Y_W-SAMPLE_W+1){y_wide[Y_W-1]}}) begin
      y_sat_next = y_wide[Y_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat_next = y_wide[SAMPLE_W-1:0];
    end
  end

  // Symmetric clamp, or the output dead band when the clamp is off.
  always_comb begin
    priority if (!drive_limit[LIMIT_W-1]) begin
      priority if (y_sat >= drive_limit) begin
        y_fin = drive_limit;
      end else if (y_sat <= -drive_limit) begin
        y_fin = -drive_limit;
      end else begin
        y_fin = y_sat;
      end
    end else if (!drive_floor[LIMIT_W-1] && (y_sat <= drive_floor) &&
                 (y_sat >= -drive_floor)) begin
      y_fin = '0;
    end else begin
      y_fin = y_sat;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_MUL1;
      ST_MUL1:  if (mul1_end) state_next = ST_BAND;
      ST_BAND:  state_next = ST_MUL2;
      ST_MUL2:  if (m0_done) state_next = ST_SUM;
      ST_SUM:   state_next = ST_SAT;
      ST_SAT:   state_next = ST_CLAMP;
      ST_CLAMP: if (out_free) state_next = ST_IDLE;
    endcase
  end

  // Controls decoded from the state.
  always_comb begin
    in_ready   = 1'b0;
    m0_load    = 1'b0;
    pd_load    = 1'b0;
    drive_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_PREP: begin
        m0_load = 1'b1;
        pd_load = 1'b1;
      end
      ST_BAND:  m0_load = 1'b1;
      ST_CLAMP: drive_load = out_free;
      ST_MUL1, ST_MUL2, ST_SUM, ST_SAT: ;
    endcase
  end

  // State, integral and previous error.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        last_error <= e_dz;
      end
      if (state == ST_MUL1 && mul1_end) begin
        integral_sum <= integ_add;
      end else if (state == ST_BAND) begin
        integral_sum <= integ_dz;
      end
    end
  end

  // Datapath registers for the error and the output sum.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      e_raw <= {target[SAMPLE_W-1], target} - {sensed[SAMPLE_W-1], sensed};
    end
    if (state == ST_BAND) begin
      pd_sum <= p_prod[PD_W-1:0] + d_prod[PD_W-1:0];
    end
    if (state == ST_SUM) begin
      total <= m0_prod + {{(PROD_W-PD_W-INT_FRAC){pd_sum[PD_W-1]}}, pd_sum,
                          {INT_FRAC{1'b0}}};
    end
    if (state == ST_SAT) begin
      y_sat <= y_sat_next;
    end
    if (drive_load) begin
      drive <= y_fin;
    end
  end

  // Output request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drive_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[test/tb_pid_controller_deadzone_clamp_core.sv]
// Self-checking testbench for the PID controller core with dead zone, clamp and output dead band.
`timescale 1ns / 1ps

module tb_pid_controller_deadzone_clamp_core import pid_dzc_pkg::*; ();

  localparam int LATENCY     = 31;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 100;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_DATA_W-1:0]       data;
    logic signed [SAMPLE_W-1:0]  tgt;
    logic signed [SAMPLE_W-1:0]  meas;
    bit                          known;
    logic signed [SAMPLE_W-1:0]  want;
  } row_t;

  typedef struct packed {
    bit                          known;
    logic signed [SAMPLE_W-1:0]  want;
  } typed_drive_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] target = '0;
  logic signed [SAMPLE_W-1:0] sensed = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] drive;

  // Random idling on both sides; cleared for one long stretch.
  bit gaps_on = 1'b1;

  int mismatches = 0;
  int stall_cycles = 0;

  // Drive values still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] drive_due_q[$];
  // Hand-typed results for directed requests, one entry per request sent.
  typed_drive_t typed_drive_q[$];

  // Controller settings and state as the block should hold them.
  longint kp_r    = 0;
  longint ki_r    = 0;
  longint kd_r    = 0;
  longint step_r  = 0;
  longint band_r  = -1;
  longint limit_r = -1;
  longint floor_r = -1;
  longint integral_acc = 0;
  longint prev_error   = 0;

  pid_controller_deadzone_clamp_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .target    (target),
    .sensed    (sensed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

  always #4 clk = ~clk;

  // Advance the controller by one tick and return the drive it produces.
  function automatic logic signed [SAMPLE_W-1:0] next_drive(
    input logic signed [SAMPLE_W-1:0] tgt,
    input logic signed [SAMPLE_W-1:0] meas
  );
    longint err;
    longint acc;
    longint total;
    longint y;
    longint imax;
    imax = (64'sd1 <<< (INTEG_W - 1)) - 1;
    err = tgt;
    err = err - meas;

    // Saturating integral in Q.16 error units.
    acc = integral_acc + err * step_r;
    if (acc > imax)
      acc = imax;
    else if (acc < -imax - 1)
      acc = -imax - 1;

    // Dead zone: integral first, then the error itself.
    if (band_r >= 0) begin
      if (acc <= band_r * 65536 && acc >= -band_r * 65536)
        acc = 0;
      if (err <= band_r && err >= -band_r)
        err = 0;
    end
    integral_acc = acc;

    total = ((ki_r * acc) >>> INT_FRAC) + kp_r * err + kd_r * (err - prev_error);
    prev_error = err;

    y = total >>> 8;
    if (y > 32767)
      y = 32767;
    else if (y < -32768)
      y = -32768;

    // Symmetric clamp wins over the output dead band.
    if (limit_r >= 0) begin
      if (y >= limit_r)
        y = limit_r;
      else if (y <= -limit_r)
        y = -limit_r;
    end else if (floor_r >= 0) begin
      if (y <= floor_r && y >= -floor_r)
        y = 0;
    end
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '{ROW_WRITE, idx, data, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t tick_row(input logic signed [SAMPLE_W-1:0] tgt,
                                    input logic signed [SAMPLE_W-1:0] meas,
                                    input bit known,
                                    input logic signed [SAMPLE_W-1:0] want);
    row_t r;
    r = '{ROW_TICK, REG_UNUSED, '0, tgt, meas, known, want};
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] corner_value();
    case ($urandom_range(3))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Write one configuration register and mirror it into the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:   kp_r    = $signed(data[KP_W-1:0]);
      REG_INTEG_GAIN:  ki_r    = $signed(data[KI_W-1:0]);
      REG_DERIV_GAIN:  kd_r    = $signed(data[KD_W-1:0]);
      REG_STEP_TIME:   step_r  = data[STEP_W-1:0];
      REG_ERROR_BAND:  band_r  = $signed(data[BAND_W-1:0]);
      REG_DRIVE_LIMIT: limit_r = $signed(data[LIMIT_W-1:0]);
      REG_DRIVE_FLOOR: floor_r = $signed(data[LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  // Present one request and hold it until the block takes it.
  task automatic send_tick(input logic signed [SAMPLE_W-1:0] tgt,
                           input logic signed [SAMPLE_W-1:0] meas,
                           input bit known,
                           input logic signed [SAMPLE_W-1:0] want);
    cfg_we <= 1'b0;
    if (gaps_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    target   <= tgt;
    sensed   <= meas;
    typed_drive_q.push_back('{known, want});
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every owed drive value has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_due_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Output side backpressure.
  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= !gaps_on || ($urandom_range(99) >= 29);
  end

  // Predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    typed_drive_t tag;
    logic signed [SAMPLE_W-1:0] model_drive;
    logic signed [SAMPLE_W-1:0] due;
    if (!rst) begin
      if (in_valid && in_ready) begin
        model_drive = next_drive(target, sensed);
        tag = typed_drive_q.pop_front();
        drive_due_q.push_back(tag.known ? tag.want : model_drive);
      end
      if (out_valid && out_ready) begin
        if (drive_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected drive %0d", drive));
        end else begin
          due = drive_due_q.pop_front();
          if (drive !== due)
            report_mismatch($sformatf("drive %0d, expected %0d", drive, due));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL pid_controller_deadzone_clamp_core");
        $finish;
      end
    end
  end

  initial begin
    row_t plan[$];
    logic [CFG_DATA_W-1:0] d;
    logic [CFG_IDX_W-1:0] idx;
    bit need_settle;
    bit push_hi;
    int r;
    int setpoint;
    int tv;
    int sv;

    // Directed table: reset behavior, gain extremes, clamp, output dead band, dead zone.
    plan.push_back(tick_row(S_MAX, S_MIN, 1, 0));
    plan.push_back(tick_row(S_MIN, S_MAX, 1, 0));
    plan.push_back(tick_row(0, 0, 1, 0));
    plan.push_back(reg_row(REG_PROP_GAIN, 24'h000100));
    plan.push_back(reg_row(REG_UNUSED, 24'hFFFFFF));
    plan.push_back(tick_row(S_MAX, S_MIN, 1, S_MAX));
    plan.push_back(tick_row(S_MIN, S_MAX, 1, S_MIN));
    plan.push_back(tick_row(100, 30, 1, 70));
    plan.push_back(reg_row(REG_PROP_GAIN, 24'h008000));
    plan.push_back(tick_row(1, 0, 1, -128));
    plan.push_back(tick_row(0, 1, 1, 128));
    plan.push_back(reg_row(REG_PROP_GAIN, 24'h000100));
    plan.push_back(reg_row(REG_DRIVE_LIMIT, 24'd100));
    plan.push_back(tick_row(500, 0, 1, 100));
    plan.push_back(tick_row(-500, 0, 1, -100));
    // A zero limit forces every output to zero.
    plan.push_back(reg_row(REG_DRIVE_LIMIT, 24'd0));
    plan.push_back(tick_row(-3, 0, 1, 0));
    plan.push_back(reg_row(REG_DRIVE_LIMIT, 24'h008000));
    plan.push_back(reg_row(REG_DRIVE_FLOOR, 24'd10));
    plan.push_back(tick_row(-10, 0, 1, 0));
    plan.push_back(tick_row(11, 0, 1, 11));
    plan.push_back(reg_row(REG_DRIVE_FLOOR, 24'h007FFF));
    plan.push_back(tick_row(S_MAX, S_MIN, 1, 0));
    plan.push_back(reg_row(REG_DRIVE_FLOOR, 24'h00FFFF));
    plan.push_back(reg_row(REG_DRIVE_LIMIT, 24'h007FFF));
    plan.push_back(tick_row(S_MAX, S_MIN, 1, S_MAX));
    plan.push_back(tick_row(S_MIN, S_MAX, 1, 16'sh8001));
    plan.push_back(reg_row(REG_ERROR_BAND, 24'd5));
    plan.push_back(tick_row(5, 0, 1, 0));
    plan.push_back(tick_row(-6, 0, 1, -6));
    plan.push_back(reg_row(REG_ERROR_BAND, 24'h00FFFF));
    plan.push_back(tick_row(S_MIN, S_MAX, 1, 0));
    // Integral and derivative at their extremes; checked against the predictor.
    plan.push_back(reg_row(REG_ERROR_BAND, 24'h010000));
    plan.push_back(reg_row(REG_STEP_TIME, 24'h00FFFF));
    plan.push_back(reg_row(REG_INTEG_GAIN, 24'h008000));
    plan.push_back(reg_row(REG_DERIV_GAIN, 24'h7FFFFF));
    plan.push_back(reg_row(REG_DRIVE_LIMIT, 24'h00FFFF));
    plan.push_back(tick_row(S_MAX, S_MIN, 0, 0));
    plan.push_back(tick_row(S_MAX, S_MIN, 0, 0));
    plan.push_back(tick_row(S_MIN, S_MAX, 0, 0));
    plan.push_back(reg_row(REG_DERIV_GAIN, 24'h800000));
    plan.push_back(reg_row(REG_INTEG_GAIN, 24'h007FFF));
    plan.push_back(tick_row(0, 0, 0, 0));
    plan.push_back(tick_row(S_MIN, S_MAX, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    need_settle = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (need_settle) begin
          settle();
          need_settle = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].tgt, plan[i].meas, plan[i].known, plan[i].want);
        need_settle = 1'b1;
      end
    end

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      gaps_on = (ph != PHASES / 2);
      for (int n = 0; n < (1 << CFG_IDX_W); n++) begin
        idx = CFG_IDX_W'(n);
        r = $urandom_range(9);
        case (idx)
          REG_PROP_GAIN, REG_INTEG_GAIN: begin
            if (r < 2)
              d = (r == 0) ? 24'h008000 : 24'h007FFF;
            else if (r < 7)
              d = CFG_DATA_W'($urandom_range(1024) - 512);
            else
              d = CFG_DATA_W'($urandom);
          end
          REG_DERIV_GAIN: begin
            if (r < 2)
              d = (r == 0) ? 24'h800000 : 24'h7FFFFF;
            else if (r < 7)
              d = CFG_DATA_W'($urandom_range(8192) - 4096);
            else
              d = CFG_DATA_W'($urandom);
          end
          REG_STEP_TIME: begin
            if (r == 0)
              d = '0;
            else if (r == 1)
              d = 24'h00FFFF;
            else if (r < 6)
              d = CFG_DATA_W'($urandom_range(1, 4096));
            else
              d = CFG_DATA_W'($urandom);
          end
          REG_ERROR_BAND: begin
            if (r < 3)
              d = CFG_DATA_W'($urandom | 32'h0001_0000);
            else if (r < 8)
              d = CFG_DATA_W'($urandom_range(64));
            else
              d = CFG_DATA_W'($urandom);
          end
          REG_DRIVE_LIMIT, REG_DRIVE_FLOOR: begin
            if (r < 4)
              d = CFG_DATA_W'($urandom | 32'h0000_8000);
            else if (r < 7)
              d = CFG_DATA_W'($urandom_range(2000));
            else
              d = CFG_DATA_W'($urandom);
          end
          default: d = CFG_DATA_W'($urandom);
        endcase
        write_reg(idx, d);
      end

      setpoint = $urandom_range(65535) - 32768;
      push_hi = 1'($urandom_range(1));
      repeat (PHASE_TICKS) begin
        // Mostly tracking near a setpoint or pushing hard one way, plus noise and corners.
        r = $urandom_range(99);
        if ($urandom_range(49) == 0)
          push_hi = !push_hi;
        if (r < 25) begin
          tv = $urandom_range(65535) - 32768;
          sv = $urandom_range(65535) - 32768;
        end else if (r < 60) begin
          tv = setpoint;
          sv = setpoint + $urandom_range(600) - 300;
          if (sv > 32767)
            sv = 32767;
          else if (sv < -32768)
            sv = -32768;
        end else if (r < 80) begin
          if (push_hi) begin
            tv = 32767 - $urandom_range(255);
            sv = -32768 + $urandom_range(255);
          end else begin
            tv = -32768 + $urandom_range(255);
            sv = 32767 - $urandom_range(255);
          end
        end else begin
          tv = corner_value();
          sv = corner_value();
        end
        send_tick(tv[SAMPLE_W-1:0], sv[SAMPLE_W-1:0], 1'b0, '0);
      end
    end

    gaps_on = 1'b1;
    settle();

    if (mismatches == 0)
      $display("PASS pid_controller_deadzone_clamp_core");
    else
      $display("FAIL pid_controller_deadzone_clamp_core");
    $finish;
  end

endmodule
